// ----- rtl/core/ft12fs_pkg.sv -----
// ----------------------------------------------------------------------------
// ft12fs_pkg
// Shared types and constants of the FT1.2 frame splitter.
// ----------------------------------------------------------------------------
package ft12fs_pkg;

	// frame marker bytes
	localparam logic [7:0] START_FIXED = 8'h10;
	localparam logic [7:0] START_VAR   = 8'h68;
	localparam logic [7:0] END_BYTE    = 8'h16;
	// position of the access demand bit in the control byte
	localparam int ACD_POS = 5;

	// most result bytes one received byte can release
	localparam int RES_MAX  = 5;
	localparam int CNT_W    = $clog2(RES_MAX + 1);
	// remaining body bytes: 16-bit length plus two
	localparam int LEFT_W   = 17;
	// search window
	localparam int WIN_D    = 4;
	localparam int FILL_W   = $clog2(WIN_D + 2);

	// one result byte with its flags
	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic       first;
		logic       last;
		logic       tok;
		logic       acd;
	} ft12fs_res_t;

	// results released by one received byte
	typedef struct packed {
		logic [CNT_W-1:0]                count;
		ft12fs_res_t [RES_MAX-1:0]       res;
	} ft12fs_burst_t;

	// status of the result buffer
	typedef struct packed {
		logic             valid;
		logic             can_load;
		logic [CNT_W-1:0] count;
	} ft12fs_buf_st_t;

endpackage

// ----- rtl/core/ft12fs_parser.sv -----
// ----------------------------------------------------------------------------
// ft12fs_parser
// Frame search and body pass-through: holds the link state and works out
// the results released by one received byte.
// ----------------------------------------------------------------------------
module ft12fs_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               rx_s1,
	output ft12fs_pkg::ft12fs_burst_t burst,
	output logic                     in_body
);
	import ft12fs_pkg::*;

	logic                          in_body_q;
	logic [WIN_D-1:0][7:0]         win_q;
	logic [FILL_W-1:0]             fill_q;
	logic [LEFT_W-1:0]             left_q;
	logic                          ctrl_q;
	logic                          demand_q;

	logic [RES_MAX-1:0][7:0]       buf_v;
	logic [RES_MAX-1:0][7:0]       shifted;
	logic [FILL_W-1:0]             len;
	logic [RES_MAX-1:0]            stop;
	logic                          found;
	logic [2:0]                    sel;
	logic [FILL_W-1:0]             r_sel;
	logic                          emit_fixed;
	logic                          emit_var;
	logic                          demand_new;
	logic                          body_last;
	logic                          body_tok;
	logic [FILL_W-1:0]             fill_d;
	logic [LEFT_W-1:0]             left_hdr;

	assign in_body = in_body_q;

	// candidate bytes: held window followed by the new byte
	always_comb begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (i < WIN_D && FILL_W'(i) < fill_q) begin
				buf_v[i] = win_q[i];
			end else begin
				buf_v[i] = rx_s1;
			end
		end
		len = fill_q + FILL_W'(1);
	end

	// positions at which the search stops: a start byte still waiting for
	// more bytes or one whose frame checks out
	always_comb begin
		for (int p = 0; p < RES_MAX; p++) begin
			logic [FILL_W-1:0] r;
			r = len - FILL_W'(p);
			stop[p] = 1'b0;
			if (FILL_W'(p) < len) begin
				if (buf_v[p] == START_FIXED) begin
					stop[p] = (r < FILL_W'(5)) || (buf_v[RES_MAX-1] == END_BYTE);
				end else if (buf_v[p] == START_VAR) begin
					stop[p] = (r < FILL_W'(4)) ||
						(buf_v[(p < 2) ? p + 3 : RES_MAX-1] == START_VAR);
				end
			end
		end
	end

	// first stop position and what it means
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int p = 0; p < RES_MAX; p++) begin
			if (!found && stop[p]) begin
				found = 1'b1;
				sel   = 3'(p);
			end
		end
		r_sel      = len - FILL_W'(sel);
		shifted    = buf_v >> {sel, 3'b000};
		emit_fixed = found && (buf_v[sel] == START_FIXED) && (r_sel >= FILL_W'(5));
		emit_var   = found && (buf_v[sel] == START_VAR) && (r_sel >= FILL_W'(4));
		fill_d     = (found && !emit_fixed && !emit_var) ? r_sel : '0;
		left_hdr   = LEFT_W'({shifted[2], shifted[1]}) + LEFT_W'(2);
	end

	// body byte flags
	assign demand_new = ctrl_q ? rx_s1[ACD_POS] : demand_q;
	assign body_last  = (left_q <= LEFT_W'(1));
	assign body_tok   = (rx_s1 == END_BYTE);

	// results of this byte
	always_comb begin
		burst.count = '0;
		for (int i = 0; i < RES_MAX; i++) begin
			burst.res[i] = '{data: buf_v[i], kind: 1'b0, first: 1'b0,
				last: 1'b0, tok: 1'b0, acd: 1'b0};
		end
		if (in_body_q) begin
			burst.count = CNT_W'(1);
			burst.res[0] = '{data: rx_s1, kind: 1'b1, first: 1'b0,
				last: body_last, tok: body_last && body_tok,
				acd: body_last && body_tok && demand_new};
		end else if (emit_fixed) begin
			burst.count = CNT_W'(RES_MAX);
			for (int i = 0; i < RES_MAX; i++) begin
				burst.res[i].data  = buf_v[i];
				burst.res[i].first = (i == 0);
				burst.res[i].last  = (i == RES_MAX - 1);
				burst.res[i].tok   = (i == RES_MAX - 1);
				burst.res[i].acd   = (i == RES_MAX - 1) && buf_v[1][ACD_POS];
			end
		end else if (emit_var) begin
			burst.count = CNT_W'(4);
			for (int i = 0; i < 4; i++) begin
				burst.res[i].data  = shifted[i];
				burst.res[i].kind  = 1'b1;
				burst.res[i].first = (i == 0);
			end
		end
	end

	// link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			fill_q    <= '0;
			left_q    <= '0;
			ctrl_q    <= 1'b0;
			demand_q  <= 1'b0;
		end else if (step) begin
			if (in_body_q) begin
				ctrl_q <= 1'b0;
				if (body_last) begin
					in_body_q <= 1'b0;
					left_q    <= '0;
					fill_q    <= '0;
					demand_q  <= 1'b0;
				end else begin
					left_q   <= left_q - LEFT_W'(1);
					demand_q <= demand_new;
				end
			end else begin
				fill_q <= fill_d;
				if (emit_var) begin
					in_body_q <= 1'b1;
					left_q    <= left_hdr;
					ctrl_q    <= 1'b1;
					demand_q  <= 1'b0;
				end
			end
		end
	end

	// search window contents
	always_ff @(posedge clk) begin
		if (step && !in_body_q) begin
			for (int k = 0; k < WIN_D; k++) begin
				win_q[k] <= shifted[k];
			end
		end
	end

endmodule

// ----- rtl/core/ft12fs_burst.sv -----
// ----------------------------------------------------------------------------
// ft12fs_burst
// Result buffer: takes the results of one byte at once and hands them out
// one per cycle from its front entry while out_stall is low.
// ----------------------------------------------------------------------------
module ft12fs_burst (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  ft12fs_pkg::ft12fs_burst_t  burst,
	input  logic                      out_stall,
	output ft12fs_pkg::ft12fs_res_t    head,
	output ft12fs_pkg::ft12fs_buf_st_t st
);
	import ft12fs_pkg::*;

	ft12fs_res_t [RES_MAX-1:0] ent_q;
	logic [CNT_W-1:0]          count_q;
	logic                      drain;

	assign drain       = (count_q != '0) && !out_stall;
	assign st.valid    = (count_q != '0);
	assign st.can_load = (count_q == '0) || ((count_q == CNT_W'(1)) && !out_stall);
	assign st.count    = count_q;
	assign head        = ent_q[0];

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= burst.count;
		end else if (drain) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// entries shift toward the front as they are taken
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= burst.res;
		end else if (drain) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				ent_q[i] <= ent_q[i + 1];
			end
		end
	end

endmodule

// ----- rtl/core/ft12_frame_splitter.sv -----
// ----------------------------------------------------------------------------
// ft12_frame_splitter
// Cuts a received FT1.2 byte stream into fixed and variable-length frames.
// Input rx_valid/rx_stall/rx_byte takes one byte per request; output
// frame_valid/frame_stall carries one frame byte with its flags per request.
// A byte goes into an input register, is parsed once the buffer can take its
// results (none, one, four or five) and these land in a five-entry result
// buffer that drains one per cycle while frame_stall is low. Body bytes of a
// variable frame flow at one byte per cycle while the receiver does not stall.
// A complete fixed frame or a variable header loads five or four results; the
// input register then holds its next byte and rx_stall is high until the
// buffer is down to its last entry and that one is taken. If the receiver
// stalls, the front result holds and rx_stall rises once the input register
// is occupied. Reset clears search and body state and empties the buffer; no
// frame is in progress afterwards.
// ----------------------------------------------------------------------------
module ft12_frame_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       frame_valid,
	input  logic       frame_stall,
	output logic [7:0] frame_byte,
	output logic       frame_kind,
	output logic       first_of_frame,
	output logic       last_of_frame,
	output logic       tail_ok,
	output logic       access_demand
);
	import ft12fs_pkg::*;

	logic [7:0]     rx_s1;
	logic           valid_s1;
	logic           step;
	logic           in_body;
	ft12fs_burst_t  burst;
	ft12fs_res_t    head;
	ft12fs_buf_st_t buf_st;

	// parse when the buffer can take this byte's results
	assign step     = valid_s1 && buf_st.can_load;
	assign rx_stall = valid_s1 && !buf_st.can_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_s1 <= rx_byte;
		end
	end

	ft12fs_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_s1   (rx_s1),
		.burst   (burst),
		.in_body (in_body)
	);

	ft12fs_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.burst     (burst),
		.out_stall (frame_stall),
		.head      (head),
		.st        (buf_st)
	);

	assign frame_valid    = buf_st.valid;
	assign frame_byte     = head.data;
	assign frame_kind     = head.kind;
	assign first_of_frame = head.first;
	assign last_of_frame  = head.last;
	assign tail_ok        = head.tok;
	assign access_demand  = head.acd;

	// buffer never holds more than one byte's results
	assert property (@(posedge clk) disable iff (!arst_n)
		buf_st.count <= CNT_W'(RES_MAX))
		else $error("result buffer overfilled");

	// a body byte always yields a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		step && in_body |=> frame_valid)
		else $error("body byte lost");

	// access demand only on a good closing byte
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && access_demand |-> tail_ok && last_of_frame)
		else $error("access demand off the good last byte");

	// a frame start is never also its end
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && first_of_frame |-> !last_of_frame)
		else $error("frame starts and ends on one byte");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FT1.2 frame splitter. A short table of directed
// bytes (fixed frame, bad end byte, bad header, good and bad variable tails)
// runs first, then random frame streams mixed with noise and broken frames,
// under three sender/receiver idle profiles. A local frame parser predicts
// every output byte with its flags, and each one is compared as it is taken.
// ----------------------------------------------------------------------------
module tb_top;
	import ft12fs_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int UNTYPED     = -1;
	localparam int N_DIR       = 25;
	localparam int RAND_ITEMS  = 320;

	// directed row: byte to send, results it releases and flags of the last one
	typedef struct {
		logic [7:0] rx;
		int         n_res;
		logic       tok;
		logic       acd;
	} dir_row_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       rx_valid    = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte     = 8'h00;
	logic       frame_valid;
	logic       frame_stall = 1'b0;
	logic [7:0] frame_byte;
	logic       frame_kind;
	logic       first_of_frame;
	logic       last_of_frame;
	logic       tail_ok;
	logic       access_demand;

	// parser state of the bench
	logic        body_active  = 1'b0;
	logic [7:0]  win [4];
	int          win_cnt      = 0;
	logic [16:0] body_left    = '0;
	logic        ctrl_pending = 1'b0;
	logic        acd_latched  = 1'b0;

	// frame bytes still to come out of the block
	ft12fs_res_t frame_q [$];
	int          burst_n;
	ft12fs_res_t burst_tail;

	int err_cnt      = 0;
	int rx_count     = 0;
	int checked_cnt  = 0;
	int fixed_cnt    = 0;
	int var_cnt      = 0;
	int cycle_cnt    = 0;
	int send_idle_pct  = 32;
	int recv_stall_pct = 85;

	dir_row_t dir_tab [N_DIR] = '{
		'{8'hFF,       0,       1'b0, 1'b0},
		'{START_FIXED, UNTYPED, 1'b0, 1'b0},
		'{8'h20,       UNTYPED, 1'b0, 1'b0},
		'{8'h01,       UNTYPED, 1'b0, 1'b0},
		'{8'h31,       UNTYPED, 1'b0, 1'b0},
		'{END_BYTE,    5,       1'b1, 1'b1},
		'{START_FIXED, UNTYPED, 1'b0, 1'b0},
		'{8'hDF,       UNTYPED, 1'b0, 1'b0},
		'{8'h02,       UNTYPED, 1'b0, 1'b0},
		'{8'hE1,       UNTYPED, 1'b0, 1'b0},
		'{8'h17,       0,       1'b0, 1'b0},
		'{START_VAR,   UNTYPED, 1'b0, 1'b0},
		'{8'h00,       UNTYPED, 1'b0, 1'b0},
		'{8'h00,       UNTYPED, 1'b0, 1'b0},
		'{START_VAR,   4,       1'b0, 1'b0},
		'{8'hFF,       UNTYPED, 1'b0, 1'b0},
		'{END_BYTE,    1,       1'b1, 1'b1},
		'{START_VAR,   UNTYPED, 1'b0, 1'b0},
		'{8'h00,       UNTYPED, 1'b0, 1'b0},
		'{START_VAR,   UNTYPED, 1'b0, 1'b0},
		'{8'h00,       0,       1'b0, 1'b0},
		'{8'h00,       UNTYPED, 1'b0, 1'b0},
		'{START_VAR,   4,       1'b0, 1'b0},
		'{8'h20,       UNTYPED, 1'b0, 1'b0},
		'{8'h15,       1,       1'b0, 1'b0}
	};

	ft12_frame_splitter DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_byte     (frame_byte),
		.frame_kind     (frame_kind),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.tail_ok        (tail_ok),
		.access_demand  (access_demand)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ft12fs_res_t mk_res(input logic [7:0] d, input logic k, f, l, t, a);
		ft12fs_res_t r;
		r.data  = d;
		r.kind  = k;
		r.first = f;
		r.last  = l;
		r.tok   = t;
		r.acd   = a;
		return r;
	endfunction

	task automatic push_res(input ft12fs_res_t r);
		frame_q.push_back(r);
		burst_n++;
		burst_tail = r;
	endtask

	// frame parser: works out the frame bytes released by one received byte
	task automatic split_byte(input logic [7:0] b);
		logic [7:0] sw [5];
		int n;
		burst_n = 0;
		// body of a variable frame passes straight through
		if (body_active) begin
			if (ctrl_pending) begin
				acd_latched  = b[ACD_POS];
				ctrl_pending = 1'b0;
			end
			if (body_left <= 17'd1) begin
				push_res(mk_res(b, 1'b1, 1'b0, 1'b1, b == END_BYTE,
					(b == END_BYTE) && acd_latched));
				body_active = 1'b0;
				body_left   = '0;
				win_cnt     = 0;
				acd_latched = 1'b0;
			end else begin
				push_res(mk_res(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
				body_left = body_left - 17'd1;
			end
			return;
		end
		// search window plus the new byte
		n = win_cnt;
		for (int i = 0; i < n; i++)
			sw[i] = win[i];
		sw[n] = b;
		n++;
		while (n > 0) begin
			if (sw[0] == START_FIXED) begin
				if (n < 5)
					break;
				if (sw[4] == END_BYTE) begin
					for (int i = 0; i < 5; i++)
						push_res(mk_res(sw[i], 1'b0, i == 0, i == 4, i == 4,
							(i == 4) && sw[1][ACD_POS]));
					n = 0;
					break;
				end
			end else if (sw[0] == START_VAR) begin
				if (n < 4)
					break;
				if (sw[3] == START_VAR) begin
					for (int i = 0; i < 4; i++)
						push_res(mk_res(sw[i], 1'b1, i == 0, 1'b0, 1'b0, 1'b0));
					body_left    = {1'b0, sw[2], sw[1]} + 17'd2;
					body_active  = 1'b1;
					ctrl_pending = 1'b1;
					acd_latched  = 1'b0;
					n = 0;
					break;
				end
			end
			// front byte cannot start a frame here: drop it
			for (int i = 0; i < n - 1; i++)
				sw[i] = sw[i + 1];
			n--;
		end
		win_cnt = n;
		for (int i = 0; i < n; i++)
			win[i] = sw[i];
	endtask

	// one byte request, with random sender gaps
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall);
		rx_count++;
		split_byte(b);
		@(negedge clk);
	endtask

	task automatic send_fixed();
		send_byte(START_FIXED);
		send_byte(8'($urandom_range(255)));
		send_byte(8'($urandom_range(255)));
		send_byte(8'($urandom_range(255)));
		send_byte(END_BYTE);
	endtask

	task automatic send_var(input logic [7:0] ll, hh, tail_b);
		int body_len;
		body_len = {hh, ll} + 2;
		send_byte(START_VAR);
		send_byte(ll);
		send_byte(hh);
		send_byte(START_VAR);
		for (int k = 1; k < body_len; k++)
			send_byte(8'($urandom_range(255)));
		send_byte(tail_b);
	endtask

	// zeros never complete a frame, so they empty the search window
	task automatic flush_window();
		while (win_cnt != 0 && !body_active)
			send_byte(8'h00);
	endtask

	// one random sequence: mostly good frames, some noise and broken frames
	task automatic send_sequence();
		int pick;
		logic [7:0] ll, hh, tl, odd;
		pick = $urandom_range(99);
		if (pick < 40) begin
			send_fixed();
		end else if (pick < 75) begin
			ll = ($urandom_range(99) < 85) ? 8'($urandom_range(10)) :
				8'($urandom_range(255));
			hh = 8'h00;
			tl = ($urandom_range(99) < 80) ? END_BYTE : 8'($urandom_range(255));
			send_var(ll, hh, tl);
		end else if (pick < 87) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(255)));
			flush_window();
		end else if (pick < 94) begin
			// fixed frame with a wrong end byte
			do odd = 8'($urandom_range(255)); while (odd == END_BYTE || odd == START_VAR);
			send_byte(START_FIXED);
			repeat (3)
				send_byte(8'($urandom_range(255)));
			send_byte(odd);
			flush_window();
		end else begin
			// variable header whose second start byte is wrong
			do odd = 8'($urandom_range(255)); while (odd == START_VAR);
			send_byte(START_VAR);
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(255)));
			send_byte(odd);
			flush_window();
		end
	endtask

	// receiver stalls
	always @(negedge clk)
		frame_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);

	function automatic void check_field(input string name, input int unsigned exp_v, act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	// compare every frame byte taken with the oldest prediction
	always @(posedge clk) begin : frame_mon
		ft12fs_res_t want;
		if (arst_n && frame_valid && !frame_stall) begin
			if (frame_q.size() == 0) begin
				$error("unexpected frame byte %0h", frame_byte);
				err_cnt++;
			end else begin
				want = frame_q.pop_front();
				check_field("frame_byte", 32'(want.data), 32'(frame_byte));
				check_field("frame_kind", 32'(want.kind), 32'(frame_kind));
				check_field("first_of_frame", 32'(want.first), 32'(first_of_frame));
				check_field("last_of_frame", 32'(want.last), 32'(last_of_frame));
				check_field("tail_ok", 32'(want.tok), 32'(tail_ok));
				check_field("access_demand", 32'(want.acd), 32'(access_demand));
				checked_cnt++;
				if (want.last) begin
					if (want.kind)
						var_cnt++;
					else
						fixed_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("ft12_frame_splitter regression: fail");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			send_byte(dir_tab[i].rx);
			if (dir_tab[i].n_res != UNTYPED) begin
				if (burst_n != dir_tab[i].n_res) begin
					$error("row %0d result count: expected %0d, got %0d",
						i, dir_tab[i].n_res, burst_n);
					err_cnt++;
				end else if (burst_n > 0 && (burst_tail.tok != dir_tab[i].tok ||
						burst_tail.acd != dir_tab[i].acd)) begin
					$error("row %0d last flags: expected tok %0b acd %0b, got %0b %0b",
						i, dir_tab[i].tok, dir_tab[i].acd, burst_tail.tok, burst_tail.acd);
					err_cnt++;
				end
			end
		end

		// random streams under three idle profiles
		while (rx_count < N_DIR + RAND_ITEMS / 3)
			send_sequence();
		send_idle_pct  = 85;
		recv_stall_pct = 32;
		while (rx_count < N_DIR + 2 * RAND_ITEMS / 3)
			send_sequence();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (rx_count < N_DIR + RAND_ITEMS)
			send_sequence();
		rx_valid <= 1'b0;

		// drain
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d bytes: directed table, then random frame streams with noise",
			rx_count);
		$display("checked %0d frame bytes in %0d fixed and %0d variable frames",
			checked_cnt, fixed_cnt, var_cnt);
		if (err_cnt == 0)
			$display("ft12_frame_splitter regression: pass");
		else
			$display("ft12_frame_splitter regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ft12fs_pkg.sv
rtl/core/ft12fs_parser.sv
rtl/core/ft12fs_burst.sv
rtl/core/ft12_frame_splitter.sv
bench/tb_top.sv
